// ===== rtl/dtoi_pkg.sv =====
// Package for the decimal text to int32 unit: status codes, character codes,
// limits and the scanner state type. No dependencies.
`default_nettype none

package dtoi_pkg;

  localparam int unsigned MAX_CHARS = 15;
  localparam int unsigned COUNT_W   = 8;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned WIDE_W    = ACC_W + 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_LIM = COUNT_W'(MAX_CHARS);

  localparam logic [ACC_W-1:0] MAG_LIMIT = 32'd2147483648;
  localparam logic [ACC_W-1:0] MAG_HOLD  = 32'd2147483649;
  localparam logic [ACC_W-1:0] POS_MAX   = 32'd2147483647;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_CHAR  = 3'd2,
    ST_FRACTION  = 3'd3,
    ST_RANGE     = 3'd4,
    ST_NO_DIGITS = 3'd5
  } status_t;

  typedef struct packed {
    logic [ACC_W-1:0]   acc;
    logic               neg;
    logic               frac;
    logic               seen;
    logic [COUNT_W-1:0] count;
    status_t            err;
  } scan_state_t;

endpackage

`default_nettype wire

// ===== rtl/dtoi_if.sv =====
// Valid/ready channel interfaces for the decimal text to int32 unit.
// Does not depend on dtoi_pkg; status is a plain 3-bit vector.
`default_nettype none

interface dtoi_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface dtoi_int_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;

  modport source(output valid, output value, output status, input ready);
  modport sink(input valid, input value, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/dtoi_scan.sv =====
// Line scanner: holds the per-line state and folds in one character per step.
// Depends on dtoi_pkg.
`default_nettype none

module dtoi_scan
  import dtoi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  char_code,
  input  wire logic        last_char,
  output scan_state_t      upd
);

  scan_state_t state;
  logic [WIDE_W-1:0] wide;
  logic [WIDE_W-1:0] acc_ext;

  assign acc_ext = WIDE_W'(state.acc);
  assign wide    = (acc_ext << 3) + (acc_ext << 1) + WIDE_W'(char_code - CH_ZERO);

  always_comb begin
    upd = state;
    if (state.count >= COUNT_LIM) begin
      upd.err = ST_TOO_LONG;
    end
    if (state.count != COUNT_MAX) begin
      upd.count = state.count + COUNT_W'(1);
    end
    if (state.frac) begin
      if (char_code != CH_ZERO && upd.err == ST_OK) begin
        upd.err = ST_FRACTION;
      end
    end else if (char_code == CH_MINUS && state.count == '0) begin
      upd.neg = 1'b1;
    end else if (char_code == CH_DOT) begin
      upd.frac = 1'b1;
    end else if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
      upd.seen = 1'b1;
      if (state.acc <= MAG_LIMIT) begin
        upd.acc = (wide > WIDE_W'(MAG_LIMIT)) ? MAG_HOLD : wide[ACC_W-1:0];
      end
    end else if (upd.err == ST_OK) begin
      upd.err = ST_BAD_CHAR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (step) begin
      state <= last_char ? scan_state_t'('0) : upd;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/dtoi_finish.sv =====
// End-of-line check: turns the final scanner state into a value and status.
// Depends on dtoi_pkg.
`default_nettype none

module dtoi_finish
  import dtoi_pkg::*;
(
  input  wire scan_state_t   fin,
  output logic signed [31:0] value,
  output status_t            status
);

  always_comb begin
    status = fin.err;
    value  = '0;
    if (status == ST_OK && !fin.seen) begin
      status = ST_NO_DIGITS;
    end
    if (status == ST_OK) begin
      if (fin.neg) begin
        if (fin.acc > MAG_LIMIT) begin
          status = ST_RANGE;
        end else begin
          value = $signed(32'(-fin.acc));
        end
      end else begin
        if (fin.acc > POS_MAX) begin
          status = ST_RANGE;
        end else begin
          value = $signed(fin.acc);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_int32_unit.sv =====
// Top level of the decimal text to int32 unit: input register, scanner and
// result register. Depends on dtoi_pkg, dtoi_if, dtoi_scan and dtoi_finish.
//
//   channel   | dir | payload               | item
//   char_in   | in  | char_code, last_char  | one character of a line
//   int_out   | out | value, status         | one parsed line
//
// One character is taken per cycle while the input register can accept it;
// the last character of a line passes through the input register ahead of
// the scanner and the result register behind it, then its result is offered.
// Reset clears the line state and both valid flags. A stalled result holds
// the pipe; an empty input register can still take one more character.
`default_nettype none

module decimal_text_to_int32_unit
  import dtoi_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  dtoi_char_if.sink char_in,
  dtoi_int_if.source int_out
);

  logic        inq_valid;
  logic [7:0]  inq_char;
  logic        inq_last;
  logic        advance;
  logic        step;
  logic        res_valid;
  logic signed [31:0] res_value;
  status_t     res_status;

  scan_state_t        upd;
  logic signed [31:0] fin_value;
  status_t            fin_status;

  assign advance       = !res_valid || int_out.ready;
  assign step          = inq_valid && advance;
  assign char_in.ready = !inq_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (char_in.ready) begin
      inq_valid <= char_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_in.ready) begin
      inq_char <= char_in.char_code;
      inq_last <= char_in.last_char;
    end
  end

  dtoi_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .char_code (inq_char),
    .last_char (inq_last),
    .upd       (upd)
  );

  dtoi_finish u_finish (
    .fin    (upd),
    .value  (fin_value),
    .status (fin_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= inq_valid && inq_last;
    end
  end

  always_ff @(posedge clk) begin
    if (step && inq_last) begin
      res_value  <= fin_value;
      res_status <= fin_status;
    end
  end

  assign int_out.valid  = res_valid;
  assign int_out.value  = res_value;
  assign int_out.status = res_status;

endmodule

`default_nettype wire
